### hw/rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants for the serial to CAN frame assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  // Serial control bytes
  localparam logic [7:0] RX_RESTART   = 8'hE0;
  localparam logic [7:0] RX_CTRL_END  = 8'hE1;
  localparam logic [7:0] DATA_END     = 8'hFF;

  // Header field masks
  localparam logic [7:0] KIND_MASK    = 8'h40;
  localparam logic [7:0] DEST_HI_MASK = 8'h1F;
  localparam logic [7:0] DEST_LO_MASK = 8'h7F;
  localparam logic [7:0] SEQ_MASK     = 8'h0F;
  localparam int unsigned DEST_HI_SHIFT = 7;

  // Frame positions and limits
  localparam logic [7:0] POS_KIND        = 8'd0;
  localparam logic [7:0] POS_DEST_LO     = 8'd1;
  localparam logic [7:0] POS_SEQ         = 8'd2;
  localparam logic [7:0] PAYLOAD_START   = 8'd3;
  localparam logic [7:0] RESTART_MIN_POS = 8'd10;
  localparam logic [7:0] CTRL_END_POS    = 8'd11;
  localparam logic [7:0] CTRL_MSG_LEN    = 8'd8;
  localparam logic [7:0] LEN_MAX         = 8'hFF;

  // Store index width: seq*8 + position - 3 stays below 1024
  localparam int unsigned IDX_W = 10;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DATA = 2'd1,
    EV_CTRL = 2'd2,
    EV_READ = 2'd3
  } event_t;

  // Header part of a result, produced by the frame controller
  typedef struct packed {
    event_t      ev;
    logic [11:0] dest;
    logic [7:0]  len;
    logic        drop;
  } hdr_res_t;

  // Full result word
  typedef struct packed {
    event_t      ev;
    logic [11:0] dest;
    logic [7:0]  len;
    logic [7:0]  rd;
    logic        drop;
  } result_t;

  // Store write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } store_wr_t;

endpackage : sca_pkg

`default_nettype wire

### hw/rtl/sca_frame_ctrl.sv
// ----------------------------------------------------------------------------
// sca_frame_ctrl
// Frame header tracking: position counter, kind, destination, sequence
// number; works out the store write and the event of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_frame_ctrl #(
  parameter int unsigned STORE_BYTES = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_en,
  input  wire logic                action,
  input  wire logic [7:0]          rx_byte,
  output sca_pkg::hdr_res_t        hdr_res,
  output sca_pkg::store_wr_t       store_wr
);
  import sca_pkg::*;

  logic [7:0]       pos_r,  pos_nxt;
  logic             data_r, data_nxt;
  logic [11:0]      dest_r, dest_nxt;
  logic [3:0]       seq_r,  seq_nxt;
  logic [IDX_W-1:0] idx;
  logic             idx_ok;
  logic             payload;

  // Store index for a payload byte
  always_comb begin
    if (data_r) begin
      idx = {{(IDX_W-7){1'b0}}, seq_r, 3'b000} + IDX_W'(pos_r) - IDX_W'(PAYLOAD_START);
    end else begin
      idx = IDX_W'(pos_r) - IDX_W'(PAYLOAD_START);
    end
    idx_ok = (idx < IDX_W'(STORE_BYTES));
  end

  // Header update and event
  always_comb begin
    pos_nxt  = pos_r;
    data_nxt = data_r;
    dest_nxt = dest_r;
    seq_nxt  = seq_r;
    payload  = 1'b0;
    hdr_res  = '{ev: EV_NONE, dest: dest_r, len: 8'd0, drop: 1'b0};

    if (action) begin
      hdr_res.ev = EV_READ;
    end else if (rx_byte == RX_RESTART) begin
      if (pos_r > RESTART_MIN_POS) begin
        pos_nxt = 8'd0;
      end
    end else if (rx_byte == RX_CTRL_END) begin
      if (!data_r && pos_r == CTRL_END_POS) begin
        hdr_res.ev  = EV_CTRL;
        hdr_res.len = CTRL_MSG_LEN;
      end
    end else begin
      pos_nxt = pos_r + 8'd1;
      case (pos_r)
        POS_KIND: begin
          data_nxt = ((rx_byte & KIND_MASK) == 8'd0);
          dest_nxt = 12'(rx_byte & DEST_HI_MASK) << DEST_HI_SHIFT;
        end
        POS_DEST_LO: begin
          dest_nxt = dest_r | 12'(rx_byte & DEST_LO_MASK);
        end
        POS_SEQ: begin
          seq_nxt = 4'(rx_byte & SEQ_MASK);
        end
        default: begin
          payload = 1'b1;
          if (!idx_ok) begin
            hdr_res.drop = 1'b1;
          end else if (data_r && rx_byte == DATA_END) begin
            hdr_res.ev  = EV_DATA;
            hdr_res.len = (idx[7:0] == LEN_MAX) ? LEN_MAX : idx[7:0] + 8'd1;
          end
        end
      endcase
    end
    hdr_res.dest = dest_nxt;
  end

  // Store write request
  assign store_wr = '{en: item_en & payload & idx_ok, idx: idx, data: rx_byte};

  // Header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      data_r <= 1'b0;
      dest_r <= 12'd0;
      seq_r  <= 4'd0;
    end else if (item_en) begin
      pos_r  <= pos_nxt;
      data_r <= data_nxt;
      dest_r <= dest_nxt;
      seq_r  <= seq_nxt;
    end
  end

endmodule : sca_frame_ctrl

`default_nettype wire

### hw/rtl/sca_store.sv
// ----------------------------------------------------------------------------
// sca_store
// Payload store: one write and one registered read per cycle, with a valid
// bit per entry so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_store #(
  parameter int unsigned STORE_BYTES = 128
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sca_pkg::store_wr_t  store_wr,
  input  wire logic                rd_en,
  input  wire logic [6:0]          rd_index,
  output logic [7:0]               rd_byte
);
  import sca_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic [7:0]             mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] vld_r;
  logic [7:0]             rd_data_r;
  logic                   rd_ok_r;
  logic [IDX_W-1:0]       raddr_ext;
  logic                   raddr_ok;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;

  assign raddr_ext = IDX_W'(rd_index);
  assign raddr_ok  = (raddr_ext < IDX_W'(STORE_BYTES));
  assign raddr     = raddr_ext[AW-1:0];
  assign waddr     = store_wr.idx[AW-1:0];

  // Data array
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[waddr] <= store_wr.data;
    end
    rd_data_r <= mem[raddr];
  end

  // Valid bits and read qualifier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (store_wr.en) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_ok_r <= rd_en & raddr_ok & vld_r[raddr];
    end
  end

  assign rd_byte = rd_ok_r ? rd_data_r : 8'd0;

endmodule : sca_store

`default_nettype wire

### hw/rtl/sca_out_fifo.sv
// ----------------------------------------------------------------------------
// sca_out_fifo
// Four-entry result queue in front of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sca_pkg::result_t    push_data,
  input  wire logic                pop,
  output logic                     not_empty,
  output sca_pkg::result_t         head,
  output logic [2:0]               count
);
  import sca_pkg::*;

  result_t    q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end

  assign not_empty = (cnt_r != 3'd0);
  assign head      = q_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule : sca_out_fifo

`default_nettype wire

### hw/rtl/serial_to_can_frame_assembler.sv
// Path: an accepted word reaches out_tvalid through the result stage, then the queue.
// Throughput: one word per cycle; the 4-entry result queue absorbs stalls
// and in_tready drops only while results in flight would fill it.
// Reset: synchronous, active low; clears header state, queue and the store
// valid bits, so the payload store reads as zero at once, with no sweep.
// ----------------------------------------------------------------------------
// serial_to_can_frame_assembler
// Assembles CAN frame headers and payload from a serial byte stream and
// answers payload store reads.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_to_can_frame_assembler #(
  parameter int unsigned STORE_BYTES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
  input  wire logic        in_tuser,   // [0] action
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [11:0] dest_address, [19:12] message_length,
                                       // [27:20] read_byte, [28] store_dropped
  output logic [1:0]       out_tuser   // [1:0] event_res
);
  import sca_pkg::*;

  logic      accept;
  hdr_res_t  hdr_res;
  store_wr_t store_wr;
  logic [7:0] rd_byte;
  logic      a_v_r;
  hdr_res_t  a_res_r;
  result_t   a_result;
  result_t   head;
  logic [2:0] q_count;
  logic      pop;

  assign accept = in_tvalid & in_tready;

  sca_frame_ctrl #(.STORE_BYTES(STORE_BYTES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_en  (accept),
    .action   (in_tuser),
    .rx_byte  (in_tdata[7:0]),
    .hdr_res  (hdr_res),
    .store_wr (store_wr)
  );

  sca_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .store_wr (store_wr),
    .rd_en    (accept & in_tuser),
    .rd_index (in_tdata[14:8]),
    .rd_byte  (rd_byte)
  );

  // Result stage, aligned with the registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_res_r <= hdr_res;
    end
  end

  assign a_result = '{ev: a_res_r.ev, dest: a_res_r.dest, len: a_res_r.len,
                      rd: rd_byte, drop: a_res_r.drop};

  sca_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (a_v_r),
    .push_data (a_result),
    .pop       (pop),
    .not_empty (out_tvalid),
    .head      (head),
    .count     (q_count)
  );

  assign pop = out_tvalid & out_tready;

  // Accept while queue plus in-flight result leaves a free entry
  assign in_tready = ((q_count + {2'b00, a_v_r}) < 3'd4);

  // Output packing
  assign out_tdata = {3'b000, head.drop, head.rd, head.len, head.dest};
  assign out_tuser = head.ev;

endmodule : serial_to_can_frame_assembler

`default_nettype wire
